[rtl/utf8tv_pkg.sv]
// Shared types and constants for the UTF-8 text field validator.
// No dependencies; used by utf8tv_byte_dec and utf8_text_field_validator.
`timescale 1ns / 1ps

package utf8tv_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 15;
  localparam int unsigned CountW  = 16;

  localparam logic [CountW-1:0] LengthLimit = 16'd32767;
  localparam logic [LenW-1:0]   MaxLengthReset = 15'd4096;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  localparam logic [ByteW-1:0] ByteTerm  = 8'h00;
  localparam logic [ByteW-1:0] ByteSpace = 8'h20;
  localparam logic [ByteW-1:0] ByteDel   = 8'h7F;
  localparam logic [ByteW-1:0] ContLo    = 8'h80;
  localparam logic [ByteW-1:0] ContHi    = 8'hBF;
  localparam logic [ByteW-1:0] Lead2Lo   = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Hi   = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo   = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi   = 8'hEF;
  localparam logic [ByteW-1:0] LeadED    = 8'hED;
  localparam logic [ByteW-1:0] Lead4Lo   = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi   = 8'hF4;
  localparam logic [ByteW-1:0] AfterE0Lo = 8'hA0;
  localparam logic [ByteW-1:0] AfterEDHi = 8'h9F;
  localparam logic [ByteW-1:0] AfterF0Lo = 8'h90;
  localparam logic [ByteW-1:0] AfterF4Hi = 8'h8F;

  typedef enum logic [2:0] {
    RULE_ANY = 3'd0,
    RULE_E0  = 3'd1,
    RULE_ED  = 3'd2,
    RULE_F0  = 3'd3,
    RULE_F4  = 3'd4
  } rule_e;

  typedef struct packed {
    logic [1:0] pending;
    rule_e      rule;
    logic       error;
    logic       visible;
  } seq_state_t;

endpackage

[rtl/utf8tv_byte_dec.sv]
// Per-byte UTF-8 sequence decoder: next sequence state from current state and byte.
// Depends on utf8tv_pkg.
`timescale 1ns / 1ps

module utf8tv_byte_dec (
  input  utf8tv_pkg::seq_state_t         cur_i,
  input  logic [utf8tv_pkg::ByteW-1:0]   byte_i,
  output utf8tv_pkg::seq_state_t         nxt_o
);

  logic cont_ok;

  always_comb begin
    unique case (cur_i.rule)
      utf8tv_pkg::RULE_E0:
        cont_ok = (byte_i >= utf8tv_pkg::AfterE0Lo) && (byte_i <= utf8tv_pkg::ContHi);
      utf8tv_pkg::RULE_ED:
        cont_ok = (byte_i >= utf8tv_pkg::ContLo) && (byte_i <= utf8tv_pkg::AfterEDHi);
      utf8tv_pkg::RULE_F0:
        cont_ok = (byte_i >= utf8tv_pkg::AfterF0Lo) && (byte_i <= utf8tv_pkg::ContHi);
      utf8tv_pkg::RULE_F4:
        cont_ok = (byte_i >= utf8tv_pkg::ContLo) && (byte_i <= utf8tv_pkg::AfterF4Hi);
      default:
        cont_ok = (byte_i >= utf8tv_pkg::ContLo) && (byte_i <= utf8tv_pkg::ContHi);
    endcase
  end

  always_comb begin
    nxt_o = cur_i;
    if (byte_i != utf8tv_pkg::ByteSpace) begin
      nxt_o.visible = 1'b1;
    end
    if (cur_i.pending != 2'd0) begin
      nxt_o.rule = utf8tv_pkg::RULE_ANY;
      if (cont_ok) begin
        nxt_o.pending = cur_i.pending - 2'd1;
      end else begin
        nxt_o.error   = 1'b1;
        nxt_o.pending = 2'd0;
      end
    end else begin
      priority if (byte_i < utf8tv_pkg::ByteSpace || byte_i == utf8tv_pkg::ByteDel) begin
        nxt_o.error = 1'b1;
      end else if (byte_i < utf8tv_pkg::ContLo) begin
        nxt_o.pending = 2'd0;
      end else if (byte_i >= utf8tv_pkg::Lead2Lo && byte_i <= utf8tv_pkg::Lead2Hi) begin
        nxt_o.pending = 2'd1;
        nxt_o.rule    = utf8tv_pkg::RULE_ANY;
      end else if (byte_i >= utf8tv_pkg::Lead3Lo && byte_i <= utf8tv_pkg::Lead3Hi) begin
        nxt_o.pending = 2'd2;
        if (byte_i == utf8tv_pkg::Lead3Lo) begin
          nxt_o.rule = utf8tv_pkg::RULE_E0;
        end else if (byte_i == utf8tv_pkg::LeadED) begin
          nxt_o.rule = utf8tv_pkg::RULE_ED;
        end else begin
          nxt_o.rule = utf8tv_pkg::RULE_ANY;
        end
      end else if (byte_i >= utf8tv_pkg::Lead4Lo && byte_i <= utf8tv_pkg::Lead4Hi) begin
        nxt_o.pending = 2'd3;
        if (byte_i == utf8tv_pkg::Lead4Lo) begin
          nxt_o.rule = utf8tv_pkg::RULE_F0;
        end else if (byte_i == utf8tv_pkg::Lead4Hi) begin
          nxt_o.rule = utf8tv_pkg::RULE_F4;
        end else begin
          nxt_o.rule = utf8tv_pkg::RULE_ANY;
        end
      end else begin
        nxt_o.error = 1'b1;
      end
    end
  end

endmodule

[rtl/utf8_text_field_validator.sv]
// Top level of the streaming UTF-8 text field validator.
// Depends on utf8tv_pkg and utf8tv_byte_dec.
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+------------------------------
// cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_max_length_i[14:0]
// in      | in        | in_valid_i/in_ready_o  | text_byte_i[7:0]
// out     | out       | out_valid_o/out_ready_i| text_valid_o, text_length_o[14:0]
//
// One byte per cycle; a terminator's verdict appears in the result register
// the cycle after it is taken. A held result stalls input only when the next
// request cannot move it out (in_ready_o = !out_valid_o | out_ready_i).
// Reset clears the string state and loads max_length with 4096.
`timescale 1ns / 1ps

module utf8_text_field_validator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [utf8tv_pkg::LenW-1:0]         cfg_max_length_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [utf8tv_pkg::ByteW-1:0]        text_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                text_valid_o,
  output logic [utf8tv_pkg::LenW-1:0]         text_length_o
);

  utf8tv_pkg::seq_state_t              seq_q, seq_d, seq_dec;
  logic [utf8tv_pkg::CountW-1:0]       count_q, count_d, limit;
  logic [utf8tv_pkg::LenW-1:0]         max_len_q;
  logic                                out_valid_q, out_valid_d;
  logic                                text_valid_q, text_valid_d;
  logic [utf8tv_pkg::LenW-1:0]         text_length_q, text_length_d;
  logic                                in_fire, is_term, ok;

  utf8tv_byte_dec u_dec (
    .cur_i  (seq_q),
    .byte_i (text_byte_i),
    .nxt_o  (seq_dec)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_term     = (text_byte_i == utf8tv_pkg::ByteTerm);

  assign limit = ({1'b0, max_len_q} > utf8tv_pkg::LengthLimit) ?
                 utf8tv_pkg::LengthLimit : {1'b0, max_len_q};

  assign ok = (count_q != '0) && (count_q <= limit) && !seq_q.error &&
              (seq_q.pending == 2'd0) && seq_q.visible;

  always_comb begin
    seq_d         = seq_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    text_valid_d  = text_valid_q;
    text_length_d = text_length_q;
    if (in_fire) begin
      if (is_term) begin
        seq_d         = '0;
        count_d       = '0;
        out_valid_d   = 1'b1;
        text_valid_d  = ok;
        text_length_d = ok ? count_q[utf8tv_pkg::LenW-1:0] : '0;
      end else begin
        seq_d = seq_dec;
        if (count_q != utf8tv_pkg::CountMax) begin
          count_d = count_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      max_len_q   <= utf8tv_pkg::MaxLengthReset;
    end else begin
      seq_q       <= seq_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_max_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    text_valid_q  <= text_valid_d;
    text_length_q <= text_length_d;
  end

  assign out_valid_o   = out_valid_q;
  assign text_valid_o  = text_valid_q;
  assign text_length_o = text_length_q;

  a_term_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_term) |=> (out_valid_o && count_q == '0 && seq_q.pending == 2'd0))
    else $error("terminator did not produce a result and clear the string");

  a_invalid_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !text_valid_o) |-> (text_length_o == '0))
    else $error("invalid verdict carries a nonzero length");

  a_valid_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_term) |=> (!text_valid_o ||
      (text_length_o != '0 && {1'b0, text_length_o} <= $past(limit))))
    else $error("valid verdict with length outside the limit");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while a stalled result would be overwritten");

endmodule
